// File: src/fdd_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and fixed-point helpers for the damped feedback delay
package fdd_pkg;

    // sample and configuration widths
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 15;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = 33;
    localparam int SCALED_W   = 18;
    localparam int SUM_W      = 19;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_COEF  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN      = CFG_IDX_W'(3);

    // configuration reset values
    localparam logic [15:0]       RST_DELAY_LENGTH  = 16'd12000;
    localparam logic [GAIN_W-1:0] RST_LOWPASS_COEF  = 15'd12000;
    localparam logic [GAIN_W-1:0] RST_FEEDBACK_GAIN = 15'd14746;
    localparam logic [GAIN_W-1:0] RST_MIX_GAIN      = 15'd19661;

    // configuration register set
    typedef struct packed {
        logic [15:0]       delay_length;
        logic [GAIN_W-1:0] lowpass_coef;
        logic [GAIN_W-1:0] feedback_gain;
        logic [GAIN_W-1:0] mix_gain;
    } fdd_cfg_t;

    // q1.15 product scaling, round to nearest with ties toward plus infinity
    function automatic logic signed [SCALED_W-1:0] q15_round(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] s;
        s = p + 33'sd16384;
        return s[PROD_W-1:15];
    endfunction

    // clamp to the signed 16-bit range
    function automatic logic signed [SAMPLE_W-1:0] sat16(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SAMPLE_W-1:0] r;
        if (v > 19'sd32767) begin
            r = 16'sh7fff;
        end
        else if (v < -19'sd32768) begin
            r = 16'sh8000;
        end
        else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/fdd_ifs.sv
`timescale 1ns / 1ps
// channel interfaces: input samples, output samples and configuration writes

interface fdd_sample_in_if import fdd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface fdd_sample_out_if import fdd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

interface fdd_cfg_if import fdd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/fdd_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module fdd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/fdd_cfg_regs.sv
`timescale 1ns / 1ps
// configuration register file for the damped feedback delay
module fdd_cfg_regs import fdd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    fdd_cfg_if.sink   cfg,
    output fdd_cfg_t  regs
);

    fdd_cfg_t regs_reg;
    fdd_cfg_t regs_next;

    // writes are always taken
    assign cfg.ready = 1'b1;

    // decode one register write per transfer, unknown indexes ignored
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DELAY_LENGTH:  regs_next.delay_length  = cfg.data;
                REG_LOWPASS_COEF:  regs_next.lowpass_coef  = cfg.data[GAIN_W-1:0];
                REG_FEEDBACK_GAIN: regs_next.feedback_gain = cfg.data[GAIN_W-1:0];
                REG_MIX_GAIN:      regs_next.mix_gain      = cfg.data[GAIN_W-1:0];
                default:           regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.delay_length  <= RST_DELAY_LENGTH;
            regs_reg.lowpass_coef  <= RST_LOWPASS_COEF;
            regs_reg.feedback_gain <= RST_FEEDBACK_GAIN;
            regs_reg.mix_gain      <= RST_MIX_GAIN;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

// File: src/feedback_delay_damped.sv
`timescale 1ns / 1ps
// Feedback delay line with a one-pole lowpass in the feedback path.
// Channels: feed carries one signed 16-bit sample_in per transfer, result
// carries one signed 16-bit sample_out per transfer, cfg writes one of the
// four registers (delay_length, lowpass_coef, feedback_gain, mix_gain) per
// transfer; cfg is always ready and must be written by the user only while
// the block is idle (not enforced by the block). Each input sample yields
// exactly one output sample, registered when write-back commits.
// A new sample is taken only while idle or as write-back commits; the order
// of steps is set by the read-modify-write of the single delay memory
// (read, lowpass product, lowpass update, feedback product, write-back);
// a same-address read is forwarded from the write data.
// Reset: the memory is not cleared; a fill mark built from the write pointer
// and a wrap flag makes never-written entries read as zero, so the block is
// ready right after reset with no clearing pass. Pointer and lowpass state
// return to zero and the registers to their defaults.
// Stall: a result waits in the output register; while it is not taken the
// next sample holds in write-back and no further input is taken.
module feedback_delay_damped import fdd_pkg::*; #(
    parameter int MEMORY_DEPTH = 65536
) (
    input  logic            clk,
    input  logic            rst_n,
    fdd_sample_in_if.sink   feed,
    fdd_sample_out_if.source result,
    fdd_cfg_if.sink         cfg
);

    localparam int AW = $clog2(MEMORY_DEPTH);
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEMORY_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(MEMORY_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_TAP   = 5'b00010,
        ST_DAMP  = 5'b00100,
        ST_FEED  = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    fdd_cfg_t cfg_regs;

    state_t                     state_reg, state_next;
    logic [AW-1:0]              wp_reg, wp_next;
    logic                       wrapped_reg, wrapped_next;
    logic signed [SAMPLE_W-1:0] ds_reg, ds_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_data_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       tap_ok_reg;
    logic                       fwd_reg;
    logic signed [SAMPLE_W-1:0] fwd_data_reg;
    logic signed [PROD_W-1:0]   prod_lp_reg;
    logic signed [31:0]         prod_mix_reg;
    logic signed [31:0]         prod_fb_reg;

    logic                       out_free;
    logic                       commit;
    logic                       in_fire;
    logic [AW-1:0]              wp_inc;
    logic [AW-1:0]              wp_cur;
    logic                       wrapped_cur;
    logic [AW-1:0]              delay_eff;
    logic [CW-1:0]              rd_diff;
    logic [CW-1:0]              rd_wrap;
    logic [AW-1:0]              rd_addr;
    logic                       rd_ok;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] tap;
    logic signed [16:0]         lp_diff;
    logic signed [SAMPLE_W-1:0] coef_s;
    logic signed [SAMPLE_W-1:0] mix_s;
    logic signed [SAMPLE_W-1:0] fb_s;
    logic signed [SAMPLE_W-1:0] fb_sum;
    logic signed [SAMPLE_W-1:0] y_sum;

    fdd_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    // handshakes
    assign out_free     = !out_valid_reg || result.ready;
    assign commit       = (state_reg == ST_WRITE) && out_free;
    assign feed.ready   = (state_reg == ST_IDLE) || commit;
    assign in_fire      = feed.valid && feed.ready;
    assign result.valid = out_valid_reg;
    assign result.sample_out = out_data_reg;

    // write pointer as seen by a sample taken this cycle
    assign wp_inc      = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
    assign wp_cur      = commit ? wp_inc : wp_reg;
    assign wrapped_cur = wrapped_reg || (commit && (wp_reg == LAST_ADDR));

    // effective delay clamped to one through depth minus one
    always_comb
    begin
        priority if (cfg_regs.delay_length == 16'd0)
        begin
            delay_eff = AW'(1);
        end
        else if ({1'b0, cfg_regs.delay_length} > 17'(MEMORY_DEPTH - 1))
        begin
            delay_eff = LAST_ADDR;
        end
        else
        begin
            delay_eff = cfg_regs.delay_length[AW-1:0];
        end
    end

    // circular read address and fill check
    assign rd_diff = {1'b0, wp_cur} - {1'b0, delay_eff};
    assign rd_wrap = rd_diff[CW-1] ? rd_diff + DEPTH_C : rd_diff;
    assign rd_addr = rd_wrap[AW-1:0];
    assign rd_ok   = wrapped_cur || (rd_addr < wp_cur);

    fdd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MEMORY_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (commit),
        .waddr (wp_reg),
        .wdata (fb_sum),
        .re    (in_fire),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // tap: zero if never written, forwarded if just written
    always_comb
    begin
        priority if (!tap_ok_reg)
        begin
            tap = '0;
        end
        else if (fwd_reg)
        begin
            tap = fwd_data_reg;
        end
        else
        begin
            tap = signed'(ram_rdata);
        end
    end

    // datapath operands
    assign lp_diff = 17'(tap) - 17'(ds_reg);
    assign coef_s  = signed'({1'b0, cfg_regs.lowpass_coef});
    assign mix_s   = signed'({1'b0, cfg_regs.mix_gain});
    assign fb_s    = signed'({1'b0, cfg_regs.feedback_gain});
    assign fb_sum  = sat16(SUM_W'(x_reg) + SUM_W'(q15_round(PROD_W'(prod_fb_reg))));
    assign y_sum   = sat16(SUM_W'(x_reg) + SUM_W'(q15_round(PROD_W'(prod_mix_reg))));

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        ds_next        = ds_reg;
        out_valid_next = out_valid_reg && !result.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_TAP;
                end
            end
            ST_TAP:
            begin
                state_next = ST_DAMP;
            end
            ST_DAMP:
            begin
                ds_next    = sat16(SUM_W'(ds_reg) + SUM_W'(q15_round(prod_lp_reg)));
                state_next = ST_FEED;
            end
            ST_FEED:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (commit)
                begin
                    wp_next        = wp_inc;
                    wrapped_next   = wrapped_cur;
                    out_valid_next = 1'b1;
                    state_next     = in_fire ? ST_TAP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            ds_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            ds_reg        <= ds_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sample capture, forwarding and products
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg        <= feed.sample_in;
            tap_ok_reg   <= rd_ok;
            fwd_reg      <= commit && (rd_addr == wp_reg);
            fwd_data_reg <= fb_sum;
        end
        if (state_reg == ST_TAP)
        begin
            prod_lp_reg  <= PROD_W'(coef_s) * PROD_W'(lp_diff);
            prod_mix_reg <= 32'(mix_s) * 32'(tap);
        end
        if (state_reg == ST_FEED)
        begin
            prod_fb_reg <= 32'(fb_s) * 32'(ds_reg);
        end
        if (commit)
        begin
            out_data_reg <= y_sum;
        end
    end

endmodule
